// ===== hw/rtl/cave_automaton_step_defines.svh =====
// ---------------------------------------------------------------------------
// cave automaton step assertion macros
// shared assertion forms, clocked on clk and disabled while rst is high
// ---------------------------------------------------------------------------
`ifndef CAVE_AUTOMATON_STEP_DEFINES_SVH
`define CAVE_AUTOMATON_STEP_DEFINES_SVH

// same-cycle implication
`define CAVE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CAVE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cave_pkg.sv =====
// ---------------------------------------------------------------------------
// cave automaton package
// widths, register codes, word types and the line mask function
// ---------------------------------------------------------------------------
`default_nettype none

package cave_pkg;

  localparam int LINE_CELLS_MAX = 64;
  localparam int LINE_W         = LINE_CELLS_MAX;
  localparam int LEN_W          = 7;
  localparam int LIMIT_W        = 4;
  localparam int COUNT_W        = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 7;
  localparam int HELD_W         = 2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [LIMIT_W-1:0] DIE_BELOW_RST      = LIMIT_W'(3);
  localparam logic [LIMIT_W-1:0] GROW_ABOVE_RST     = LIMIT_W'(4);
  localparam logic [LEN_W-1:0]   CELLS_PER_LINE_RST = LEN_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIE_BELOW      = 2'd0,
    REG_GROW_ABOVE     = 2'd1,
    REG_CELLS_PER_LINE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] die_below;
    logic [LIMIT_W-1:0] grow_above;
  } cave_limits_t;

  typedef struct packed {
    logic [LINE_W-1:0] next_line_cells;
    logic              end_of_grid;
  } cave_word_t;

  typedef struct packed {
    logic push0;
    logic push1;
  } cave_push_t;

  typedef struct packed {
    logic [FIFO_LVL_W-1:0] level;
  } cave_fifo_status_t;

  // cells at or beyond the line length read as wall; lengths above the line
  // width simply select every cell
  function automatic logic [LINE_W-1:0] line_mask(input logic [LEN_W-1:0] n);
    logic [LINE_W-1:0] m;
    for (int k = 0; k < LINE_W; k++) begin
      m[k] = (32'(n) > k);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cave_ifs.sv =====
// ---------------------------------------------------------------------------
// cave automaton channel interfaces
// valid/ready channels for input lines, result lines and register writes
// ---------------------------------------------------------------------------
`default_nettype none

interface cave_in_if;
  import cave_pkg::*;
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] line_cells;
  logic              final_line;
  modport source (output valid, output line_cells, output final_line, input ready);
  modport sink   (input valid, input line_cells, input final_line, output ready);
endinterface

interface cave_out_if;
  import cave_pkg::*;
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] next_line_cells;
  logic              end_of_grid;
  modport source (output valid, output next_line_cells, output end_of_grid, input ready);
  modport sink   (input valid, input next_line_cells, input end_of_grid, output ready);
endinterface

interface cave_cfg_if;
  import cave_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cave_automaton_step.sv =====
// ---------------------------------------------------------------------------
// cave automaton step
// one generation of a binary cave automaton over a 3x3 neighbourhood
// ---------------------------------------------------------------------------
// Grid lines arrive one word per line on line_in (bit k is cell k, 1 floor,
// 0 wall) and the next generation leaves on result_out, one word per line,
// each line emitted once the line below it has arrived. The word marked
// final_line flushes two words, the second with end_of_grid set; a grid of a
// single line gives one word. The block takes one line per cycle while
// line_in is ready: two banks of 64 cell lanes evaluate the line above
// and the current line in the cycle the word is taken, and their results
// drop into a four-word output queue. line_in is ready while that queue
// holds at most two words, so with the consumer always ready a grid
// streams in with no stall and its results drain at one word per cycle,
// the final line giving one extra word. The queue decouples the two sides
// until it holds three words. Registers (die_below, grow_above,
// cells_per_line) are written on cfg and should change only between grids.
// ---------------------------------------------------------------------------
`default_nettype none

`include "cave_automaton_step_defines.svh"

module cave_automaton_step (
  input  logic       clk,
  input  logic       rst,
  cave_in_if.sink    line_in,
  cave_out_if.source result_out,
  cave_cfg_if.sink   cfg
);
  import cave_pkg::*;

  // configuration registers
  logic [LIMIT_W-1:0] die_below;
  logic [LIMIT_W-1:0] grow_above;
  logic [LEN_W-1:0]   cells_per_line;
  cave_limits_t       limits;
  logic [LINE_W-1:0]  mask;

  // line buffer state
  logic [LINE_W-1:0]  line_above;
  logic [LINE_W-1:0]  line_middle;
  logic [HELD_W-1:0]  lines_held;

  logic               in_acc;
  logic [LINE_W-1:0]  cur;
  logic [LINE_W-1:0]  res_mid;   // next gen of the middle line
  logic [LINE_W-1:0]  res_cur;   // next gen of the incoming line, last row
  cave_push_t         push;
  cave_word_t         word0;
  cave_word_t         word1;
  cave_word_t         out_word;
  cave_fifo_status_t  fifo_status;

  // register writes, always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      die_below      <= DIE_BELOW_RST;
      grow_above     <= GROW_ABOVE_RST;
      cells_per_line <= CELLS_PER_LINE_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_DIE_BELOW:      die_below      <= cfg.data[LIMIT_W-1:0];
        REG_GROW_ABOVE:     grow_above     <= cfg.data[LIMIT_W-1:0];
        REG_CELLS_PER_LINE: cells_per_line <= cfg.data[LEN_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign limits.die_below  = die_below;
  assign limits.grow_above = grow_above;
  assign mask = line_mask(cells_per_line);

  // input side: room for the two words a final line may produce
  assign line_in.ready = (fifo_status.level <= FIFO_LVL_W'(FIFO_DEPTH - 2));
  assign in_acc = line_in.valid && line_in.ready;
  assign cur    = line_in.line_cells & mask;

  // middle line with the incoming line below it
  cave_line_unit u_unit_mid (
    .up     (line_above),
    .mid    (line_middle),
    .down   (cur),
    .limits (limits),
    .mask   (mask),
    .result (res_mid)
  );

  // incoming line as the bottom row; middle is all wall when nothing is held
  cave_line_unit u_unit_cur (
    .up     (line_middle),
    .mid    (cur),
    .down   ('0),
    .limits (limits),
    .mask   (mask),
    .result (res_cur)
  );

  // word selection: a first line that is also final gives only its own row
  always_comb begin
    push.push0 = in_acc && ((lines_held != '0) || line_in.final_line);
    push.push1 = in_acc && (lines_held != '0) && line_in.final_line;
    word1.next_line_cells = res_cur;
    word1.end_of_grid     = 1'b1;
    if (lines_held != '0) begin
      word0.next_line_cells = res_mid;
      word0.end_of_grid     = 1'b0;
    end else begin
      word0 = word1;
    end
  end

  // line buffer update
  always_ff @(posedge clk) begin
    if (rst) begin
      line_above  <= '0;
      line_middle <= '0;
      lines_held  <= '0;
    end else if (in_acc) begin
      if (line_in.final_line) begin
        line_above  <= '0;
        line_middle <= '0;
        lines_held  <= '0;
      end else begin
        line_above  <= line_middle;
        line_middle <= cur;
        lines_held  <= (lines_held == '0) ? HELD_W'(1) : HELD_W'(2);
      end
    end
  end

  cave_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .word0     (word0),
    .word1     (word1),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_word  (out_word),
    .status    (fifo_status)
  );

  assign result_out.next_line_cells = out_word.next_line_cells;
  assign result_out.end_of_grid     = out_word.end_of_grid;

  // checks
  `CAVE_ASSERT_NOW(a_level_max, 1'b1, fifo_status.level <= FIFO_LVL_W'(FIFO_DEPTH), "result queue overflow")
  `CAVE_ASSERT_NOW(a_empty_clear, lines_held == '0, line_middle == '0 && line_above == '0, "line buffer not clear while empty")
  `CAVE_ASSERT_NEXT(a_final_flush, in_acc && line_in.final_line, lines_held == '0, "final line did not flush state")
  `CAVE_ASSERT_NEXT(a_hold_line, in_acc && !line_in.final_line, lines_held != '0, "line not held after accept")

endmodule

`default_nettype wire

// ===== hw/rtl/cave_cell_lane.sv =====
// ---------------------------------------------------------------------------
// cave cell lane
// neighbour count and survive/birth rule for one cell
// ---------------------------------------------------------------------------
`default_nettype none

module cave_cell_lane (
  input  logic [7:0]           nbrs,
  input  logic                 self_floor,
  input  cave_pkg::cave_limits_t limits,
  output logic                 cell_next
);
  import cave_pkg::*;

  logic [COUNT_W-1:0] cnt;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + COUNT_W'(nbrs[i]);
    end
  end

  always_comb begin
    if (self_floor) begin
      cell_next = !(cnt < limits.die_below);
    end else begin
      cell_next = (cnt > limits.grow_above);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cave_line_unit.sv =====
// ---------------------------------------------------------------------------
// cave line unit
// one lane per cell across a line, merged and masked to the line length
// ---------------------------------------------------------------------------
`default_nettype none

module cave_line_unit (
  input  logic [cave_pkg::LINE_W-1:0] up,
  input  logic [cave_pkg::LINE_W-1:0] mid,
  input  logic [cave_pkg::LINE_W-1:0] down,
  input  cave_pkg::cave_limits_t      limits,
  input  logic [cave_pkg::LINE_W-1:0] mask,
  output logic [cave_pkg::LINE_W-1:0] result
);
  import cave_pkg::*;

  // one wall cell of padding on each side of every line
  logic [LINE_W+1:0] up_pad;
  logic [LINE_W+1:0] mid_pad;
  logic [LINE_W+1:0] down_pad;
  logic [LINE_W-1:0] lane_bits;

  assign up_pad   = {1'b0, up, 1'b0};
  assign mid_pad  = {1'b0, mid, 1'b0};
  assign down_pad = {1'b0, down, 1'b0};

  for (genvar k = 0; k < LINE_W; k++) begin : g_lane
    cave_cell_lane u_lane (
      .nbrs       ({up_pad[k+2:k], mid_pad[k+2], mid_pad[k], down_pad[k+2:k]}),
      .self_floor (mid[k]),
      .limits     (limits),
      .cell_next  (lane_bits[k])
    );
  end

  assign result = lane_bits & mask;

endmodule

`default_nettype wire

// ===== hw/rtl/cave_result_fifo.sv =====
// ---------------------------------------------------------------------------
// cave result fifo
// small output queue taking up to two words per cycle, giving one
// ---------------------------------------------------------------------------
`default_nettype none

module cave_result_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  cave_pkg::cave_push_t         push,
  input  cave_pkg::cave_word_t         word0,
  input  cave_pkg::cave_word_t         word1,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cave_pkg::cave_word_t         out_word,
  output cave_pkg::cave_fifo_status_t  status
);
  import cave_pkg::*;

  cave_word_t            mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_LVL_W-1:0] level;
  logic [FIFO_LVL_W-1:0] n_push;
  logic                  pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (level != '0);
  assign out_word  = mem[rd_ptr];
  assign n_push    = FIFO_LVL_W'(push.push0) + FIFO_LVL_W'(push.push1);
  assign status.level = level;

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr] <= word0;
    end
    if (push.push1) begin
      mem[wr_ptr + FIFO_PTR_W'(1)] <= word1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      level <= level + n_push - FIFO_LVL_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== bench/cave_automaton_step_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cave automaton step testbench
// streams grids of lines through the block under random stalls on both sides
// and checks every result word against a line-by-line shadow of the cave rule
// ---------------------------------------------------------------------------

module cave_automaton_step_test;
  import cave_pkg::*;

  // register index that maps to no register; a write to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES  = 4;     // quiet cycles before a register write
  localparam int TAIL_CYCLES    = 8;     // cycles left after the last word
  localparam int RANDOM_LINES   = 880;
  localparam int PRINT_CAP      = 40;

  typedef enum logic [0:0] {
    ROW_LINE,
    ROW_REG
  } row_kind_t;

  // one row of the directed table: either a register write or a grid line,
  // optionally with its result lines written out by hand
  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [LINE_W-1:0]     cells;
    logic                  fin;
    logic                  typed;
    logic [LINE_W-1:0]     typed0;
    logic [LINE_W-1:0]     typed1;
  } stim_row_t;

  logic clk;
  logic rst;

  cave_in_if  line_ch ();
  cave_out_if result_ch ();
  cave_cfg_if cfg_ch ();

  cave_automaton_step uut (
    .clk        (clk),
    .rst        (rst),
    .line_in    (line_ch),
    .result_out (result_ch),
    .cfg        (cfg_ch)
  );

  // shadow copy of the registers
  logic [LIMIT_W-1:0] death_reg;
  logic [LIMIT_W-1:0] birth_reg;
  logic [LEN_W-1:0]   len_reg;

  // shadow copy of the line buffers
  logic [LINE_W-1:0] shadow_above;
  logic [LINE_W-1:0] shadow_middle;
  int                shadow_held;

  cave_word_t pending_words[$];   // result words still owed by the block
  stim_row_t  directed_rows[$];

  int mismatch_count = 0;
  bit quiet = 0;           // no idling on either side
  bit hold_request = 0;    // asks the receiver for one long hold-off
  int hold_left = 0;
  int stall_cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cells in use under the current length; lengths above the width saturate
  function automatic logic [LINE_W-1:0] live_mask();
    logic [LINE_W-1:0] m;
    int                n;
    n = (len_reg > LINE_CELLS_MAX) ? LINE_CELLS_MAX : int'(len_reg);
    for (int k = 0; k < LINE_W; k++) begin
      m[k] = (k < n);
    end
    return m;
  endfunction

  // next generation of mid, with up and down as its neighbor lines
  function automatic logic [LINE_W-1:0] evolve_line(input logic [LINE_W-1:0] up,
                                                    input logic [LINE_W-1:0] mid,
                                                    input logic [LINE_W-1:0] down);
    logic [LINE_W+1:0] u;
    logic [LINE_W+1:0] m;
    logic [LINE_W+1:0] d;
    logic [LINE_W-1:0] res;
    int                cnt;
    // pad with a wall cell at both ends, cell k sits at k+1
    u = {1'b0, up, 1'b0};
    m = {1'b0, mid, 1'b0};
    d = {1'b0, down, 1'b0};
    for (int k = 0; k < LINE_W; k++) begin
      cnt = int'(u[k]) + int'(u[k+1]) + int'(u[k+2]) + int'(m[k]) + int'(m[k+2])
          + int'(d[k]) + int'(d[k+1]) + int'(d[k+2]);
      if (mid[k]) begin
        res[k] = !(cnt < int'(death_reg));
      end else begin
        res[k] = cnt > int'(birth_reg);
      end
    end
    return res & live_mask();
  endfunction

  task automatic report_mismatch(input string what, input logic [LINE_W-1:0] got,
                                 input logic [LINE_W-1:0] want);
    if (mismatch_count < PRINT_CAP) begin
      $display("mismatch %s: got %h want %h", what, got, want);
    end
    mismatch_count++;
  endtask

  // offer one grid line, wait for it to be taken, then work out what it owes
  task automatic send_line(input logic [LINE_W-1:0] cells, input logic fin,
                           input logic typed, input logic [LINE_W-1:0] typed0,
                           input logic [LINE_W-1:0] typed1);
    cave_word_t        words[2];
    int                n;
    logic [LINE_W-1:0] cur;
    // random gaps, with junk on the payload while valid is low
    while (!quiet && $urandom_range(99) < 9) begin
      line_ch.valid      <= 1'b0;
      line_ch.line_cells <= {$urandom, $urandom};
      line_ch.final_line <= $urandom_range(1);
      @(posedge clk);
    end
    line_ch.valid      <= 1'b1;
    line_ch.line_cells <= cells;
    line_ch.final_line <= fin;
    do @(posedge clk); while (!line_ch.ready);

    // mask applied on arrival, kept by the stored line
    cur = cells & live_mask();
    n = 0;
    if (shadow_held == 0) begin
      if (fin) begin
        // single-line grid
        words[0].next_line_cells = evolve_line('0, cur, '0);
        words[0].end_of_grid     = 1'b1;
        n = 1;
      end else begin
        shadow_above  = '0;
        shadow_middle = cur;
        shadow_held   = 1;
      end
    end else begin
      words[0].next_line_cells = evolve_line(shadow_above, shadow_middle, cur);
      words[0].end_of_grid     = 1'b0;
      n = 1;
      if (fin) begin
        // last line flushes its own result as well
        words[1].next_line_cells = evolve_line(shadow_middle, cur, '0);
        words[1].end_of_grid     = 1'b1;
        n = 2;
      end else begin
        shadow_above  = shadow_middle;
        shadow_middle = cur;
        shadow_held   = 2;
      end
    end
    if (fin) begin
      shadow_above  = '0;
      shadow_middle = '0;
      shadow_held   = 0;
    end
    for (int i = 0; i < n; i++) begin
      if (typed) begin
        words[i].next_line_cells = (i == 0) ? typed0 : typed1;
      end
      pending_words.push_back(words[i]);
    end
  endtask

  // register write, only once the block has nothing left to deliver
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    line_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_DIE_BELOW: begin
        death_reg = data[LIMIT_W-1:0];
      end
      REG_GROW_ABOVE: begin
        birth_reg = data[LIMIT_W-1:0];
      end
      REG_CELLS_PER_LINE: begin
        len_reg = data;
      end
      default: begin
      end
    endcase
  endtask

  task automatic row_line(input logic [LINE_W-1:0] cells, input logic fin,
                          input logic typed, input logic [LINE_W-1:0] typed0,
                          input logic [LINE_W-1:0] typed1);
    stim_row_t r;
    r.kind   = ROW_LINE;
    r.idx    = REG_UNUSED;
    r.data   = '0;
    r.cells  = cells;
    r.fin    = fin;
    r.typed  = typed;
    r.typed0 = typed0;
    r.typed1 = typed1;
    directed_rows.push_back(r);
  endtask

  task automatic row_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r.kind   = ROW_REG;
    r.idx    = idx;
    r.data   = data;
    r.cells  = '0;
    r.fin    = 1'b0;
    r.typed  = 1'b0;
    r.typed0 = '0;
    r.typed1 = '0;
    directed_rows.push_back(r);
  endtask

  // receiver: random idling, plus one long hold-off so the block backs up
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= quiet || ($urandom_range(99) >= 9);
      end
    end
  end

  // result checker: each taken word against the oldest owed word
  always @(posedge clk) begin : check_results
    cave_word_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("word with nothing owed", result_ch.next_line_cells, '0);
      end else begin
        want = pending_words.pop_front();
        if (result_ch.next_line_cells !== want.next_line_cells) begin
          report_mismatch("next_line_cells", result_ch.next_line_cells,
                          want.next_line_cells);
        end
        if (result_ch.end_of_grid !== want.end_of_grid) begin
          report_mismatch("end_of_grid", LINE_W'(result_ch.end_of_grid),
                          LINE_W'(want.end_of_grid));
        end
      end
    end
  end

  // watchdog: any handshake clears the count
  always @(posedge clk) begin
    if (rst || (line_ch.valid && line_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // main stimulus
  initial begin
    logic [LINE_W-1:0]     cells;
    logic [LIMIT_W-1:0]    lim;
    logic [CFG_DATA_W-1:0] len;
    int                    lines_sent;
    int                    glen;
    int                    r;
    bit                    hold_issued;

    rst                <= 1'b1;
    line_ch.valid      <= 1'b0;
    line_ch.line_cells <= '0;
    line_ch.final_line <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_DIE_BELOW;
    cfg_ch.data        <= '0;

    death_reg     = DIE_BELOW_RST;
    birth_reg     = GROW_ABOVE_RST;
    len_reg       = CELLS_PER_LINE_RST;
    shadow_above  = '0;
    shadow_middle = '0;
    shadow_held   = 0;

    // reset settings: a lone floor line has at most two neighbors, so it dies
    row_line('1, 1'b1, 1'b1, '0, '0);
    row_line('0, 1'b1, 1'b1, '0, '0);
    // three all-floor lines: every cell keeps at least three floor neighbors
    row_line('1, 1'b0, 1'b0, '0, '0);
    row_line('1, 1'b0, 1'b1, '1, '0);
    row_line('1, 1'b1, 1'b1, '1, '1);
    // death limit above eight kills all floor, birth limit eight never births
    row_reg(REG_DIE_BELOW, 7'd9);
    row_reg(REG_GROW_ABOVE, 7'd8);
    row_line('1, 1'b1, 1'b1, '0, '0);
    row_line('1, 1'b0, 1'b0, '0, '0);
    row_line('1, 1'b1, 1'b1, '0, '0);
    // zero limits: floor never dies, any neighbor births
    row_reg(REG_DIE_BELOW, 7'd0);
    row_reg(REG_GROW_ABOVE, 7'd0);
    row_line(64'h1, 1'b1, 1'b1, 64'h3, '0);
    // zero length: every line reads as wall
    row_reg(REG_CELLS_PER_LINE, 7'd0);
    row_line('1, 1'b1, 1'b1, '0, '0);
    // one cell in use
    row_reg(REG_CELLS_PER_LINE, 7'd1);
    row_line('1, 1'b1, 1'b1, 64'h1, '0);
    // upper data bits ignored on the limit registers; length saturates
    row_reg(REG_DIE_BELOW, 7'h73);
    row_reg(REG_GROW_ABOVE, 7'h74);
    row_reg(REG_CELLS_PER_LINE, 7'd127);
    row_line(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, '0, '0);
    row_line(64'h5555_5555_5555_5555, 1'b1, 1'b0, '0, '0);
    // length changed between lines of one grid
    row_reg(REG_CELLS_PER_LINE, 7'd64);
    row_line(64'hF0F0_3C3C_FF00_1248, 1'b0, 1'b0, '0, '0);
    row_reg(REG_CELLS_PER_LINE, 7'd10);
    row_line(64'h8421_FFFF_0F0F_03FF, 1'b0, 1'b0, '0, '0);
    row_line(64'hFFFF_0000_FFFF_02D7, 1'b1, 1'b0, '0, '0);
    // write to the unused index
    row_reg(REG_UNUSED, 7'h7F);
    row_reg(REG_CELLS_PER_LINE, 7'd64);
    row_line(64'h7E7E_FFFF_1818_C3C3, 1'b1, 1'b0, '0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_line(directed_rows[i].cells, directed_rows[i].fin, directed_rows[i].typed,
                  directed_rows[i].typed0, directed_rows[i].typed1);
      end
    end

    // random grids
    lines_sent  = 0;
    hold_issued = 0;
    while (lines_sent < RANDOM_LINES) begin
      if (!hold_issued && lines_sent >= 100) begin
        // long grid while the receiver holds off, so the output queue backs up
        hold_issued  = 1;
        hold_request = 1;
        glen         = 24;
      end else begin
        if ($urandom_range(5) == 0) begin
          // new settings between grids, extremes included
          case ($urandom_range(4))
            0: lim = 4'd0;
            1: lim = 4'd9;
            2: lim = 4'd15;
            default: lim = 4'($urandom_range(5, 2));
          endcase
          write_reg(REG_DIE_BELOW, {3'($urandom_range(7)), lim});
          case ($urandom_range(4))
            0: lim = 4'd0;
            1: lim = 4'd8;
            2: lim = 4'd15;
            default: lim = 4'($urandom_range(5, 3));
          endcase
          write_reg(REG_GROW_ABOVE, {3'($urandom_range(7)), lim});
          r = $urandom_range(9);
          case (r)
            0: len = 7'd0;
            1: len = 7'd1;
            2: len = 7'($urandom_range(127, 65));
            3, 4: len = 7'($urandom_range(63, 2));
            default: len = 7'd64;
          endcase
          write_reg(REG_CELLS_PER_LINE, len);
        end
        r = $urandom_range(99);
        if (r < 10) begin
          glen = 1;
        end else if (r < 80) begin
          glen = $urandom_range(6, 2);
        end else if (r < 95) begin
          glen = $urandom_range(16, 7);
        end else begin
          glen = $urandom_range(40, 17);
        end
      end
      // a stretch with no idling on either side
      quiet = (lines_sent >= 350 && lines_sent < 500);
      for (int i = 0; i < glen; i++) begin
        // mix of densities so counts land on both sides of the limits
        case ($urandom_range(3))
          0: cells = {$urandom, $urandom};
          1: cells = {$urandom, $urandom} & {$urandom, $urandom};
          2: cells = {$urandom, $urandom} | {$urandom, $urandom};
          default: cells = {LINE_W{$urandom_range(1) == 1}}
                           ^ (LINE_W'(1) << $urandom_range(LINE_W - 1));
        endcase
        send_line(cells, i == glen - 1, 1'b0, '0, '0);
      end
      lines_sent += glen;
    end
    quiet = 0;

    // drain
    line_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
